// ----- src/pffl_pkg.sv -----
// ----------------------------------------------------------------------------
// pffl_pkg
// Types, constants and codes shared by the page frame free list allocator.
// ----------------------------------------------------------------------------
package pffl_pkg;

  // default geometry
  localparam int NUM_PAGES_DEF = 4096;
  localparam int PAGE_SIZE_DEF = 4096;

  // fixed field widths
  localparam int ADDR_W = 48;
  localparam int BASE_W = 36;
  localparam int CNT_W  = 13;
  localparam int CFG_W  = 36;

  // request modes
  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_BUILD = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REGION = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic {
    REG_BASE_PAGE = 1'b0,
    REG_PAGES     = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_CHECK,
    S_WALK,
    S_LOAD,
    S_LINK,
    S_PREV,
    S_BUILD,
    S_DONE
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [ADDR_W-1:0]  page_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  alloc_address;
    status_t            status;
    logic [CNT_W-1:0]   free_pages;
  } rsp_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic head_nil;
    logic out_region;
    logic walk_go;
    logic need_link;
    logic build_more;
  } cond_t;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic busy;
    logic accept;
    logic rd_head;
    logic pop;
    logic check;
    logic step_rd;
    logic step_ld;
    logic wr_link;
    logic ins;
    logic build_wr;
    logic build_end;
    logic done;
  } ctrl_t;

endpackage

// ----- src/pffl_ram.sv -----
// ----------------------------------------------------------------------------
// pffl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pffl_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pffl_fsm.sv -----
// ----------------------------------------------------------------------------
// pffl_fsm
// Sequencer for allocate, free (sorted list walk) and rebuild requests.
// ----------------------------------------------------------------------------
module pffl_fsm
  import pffl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  mode_t mode,
  input  cond_t cond,
  output ctrl_t ctrl
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_ALLOC: state_next = cond.head_nil ? S_DONE : S_POP;
            MODE_FREE:  state_next = S_CHECK;
            MODE_BUILD: state_next = S_BUILD;
            MODE_RSVD:  state_next = S_DONE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_POP:   state_next = S_DONE;
      S_CHECK: state_next = cond.out_region ? S_DONE : S_WALK;
      S_WALK: begin
        if (cond.walk_go) begin
          state_next = S_LOAD;
        end else if (cond.need_link) begin
          state_next = S_LINK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LOAD:  state_next = S_WALK;
      S_LINK:  state_next = S_PREV;
      S_PREV:  state_next = S_DONE;
      S_BUILD: state_next = cond.build_more ? S_BUILD : S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    ctrl           = '0;
    ctrl.busy      = (state != S_IDLE);
    ctrl.accept    = (state == S_IDLE) && start;
    ctrl.rd_head   = ctrl.accept && (mode == MODE_ALLOC) && !cond.head_nil;
    ctrl.pop       = (state == S_POP);
    ctrl.check     = (state == S_CHECK);
    ctrl.step_rd   = (state == S_WALK) && cond.walk_go;
    ctrl.step_ld   = (state == S_LOAD);
    ctrl.wr_link   = (state == S_LINK);
    ctrl.ins       = (state == S_PREV);
    ctrl.build_wr  = (state == S_BUILD) && cond.build_more;
    ctrl.build_end = (state == S_BUILD) && !cond.build_more;
    ctrl.done      = (state == S_DONE);
  end

endmodule

// ----- src/page_frame_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator
// Keeps the free page frames of one region as a sorted singly linked list
// held in a link RAM; allocates the lowest page, inserts freed pages in order.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   start & !busy           request (mode, page_address)
//  result    done, one cycle         result (alloc_address, status, free_pages)
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
//  free walks the list entries below the freed page before linking it in,
//  and stops at the region check for a page outside the region; the walk
//  reads the link RAM through its single registered read port.
//  rst is synchronous; the list comes up empty and the link RAM is not cleared.
//  busy stays high through the done cycle; done cannot be held off.
//  NUM_PAGES must stay at or below 4096 to fit the 13-bit count ports.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator
  import pffl_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             request,
  output logic             done,
  output rsp_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LW         = $clog2(NUM_PAGES + 1);
  localparam int AW         = $clog2(NUM_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int DW         = ((PG_W > BASE_W) ? PG_W : BASE_W) + 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

  // configuration registers
  logic [BASE_W-1:0] region_base_page;
  logic [CNT_W-1:0]  region_pages;

  // list state
  logic [LW-1:0] list_head;
  logic [LW-1:0] free_total;

  // working registers
  logic [PG_W-1:0]   page_r;
  logic [LW-1:0]     idx;
  logic [LW-1:0]     cur;
  logic [LW-1:0]     prev;
  logic [LW-1:0]     steps;
  logic [LW-1:0]     cnt;
  logic [ADDR_W-1:0] res_addr;
  status_t           status_r;

  ctrl_t ctrl;
  cond_t cond;

  logic [LW-1:0]     usable;
  logic [DW-1:0]     diff;
  logic [BASE_W:0]   pg_sum;
  logic [ADDR_W-1:0] alloc_byte;
  logic [LW-1:0]     cnt_inc;
  logic [LW-1:0]     build_link;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [LW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [LW-1:0]     ram_rdata;

  // config write port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base_page <= '0;
      region_pages     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_PAGE: region_base_page <= cfg_data[BASE_W-1:0];
        REG_PAGES:     region_pages     <= cfg_data[CNT_W-1:0];
        default:       region_pages     <= region_pages;
      endcase
    end
  end

  // usable page count, clamped to the table depth
  assign usable = (region_pages > CNT_W'(NUM_PAGES)) ? NIL : LW'(region_pages);

  // region check: page offset from the region base, with borrow
  assign diff = DW'(page_r) - DW'(region_base_page);

  // byte address of the head page
  assign pg_sum     = {1'b0, region_base_page} + (BASE_W + 1)'(list_head);
  assign alloc_byte = ADDR_W'(pg_sum) << PAGE_SHIFT;

  // rebuild link value
  assign cnt_inc    = cnt + LW'(1);
  assign build_link = (cnt_inc < usable) ? cnt_inc : NIL;

  // conditions for the sequencer
  always_comb begin
    cond.head_nil   = (list_head >= NIL);
    cond.out_region = diff[DW-1] || (diff[DW-2:0] >= (DW - 1)'(usable));
    cond.walk_go    = (cur < NIL) && (cur < idx) && (steps < NIL);
    cond.need_link  = (cur != idx);
    cond.build_more = (cnt < usable);
  end

  pffl_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (request.mode),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  // link RAM port selection
  always_comb begin
    ram_re    = ctrl.rd_head || ctrl.step_rd;
    ram_raddr = ctrl.rd_head ? list_head[AW-1:0] : cur[AW-1:0];
    ram_we    = ctrl.build_wr || ctrl.wr_link || (ctrl.ins && (prev < NIL));
    ram_waddr = prev[AW-1:0];
    ram_wdata = idx;
    if (ctrl.build_wr) begin
      ram_waddr = cnt[AW-1:0];
      ram_wdata = build_link;
    end else if (ctrl.wr_link) begin
      ram_waddr = idx[AW-1:0];
      ram_wdata = cur;
    end
  end

  pffl_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // list head and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      list_head  <= NIL;
      free_total <= '0;
    end else begin
      if (ctrl.pop) begin
        list_head <= ram_rdata;
        if (free_total != '0) begin
          free_total <= free_total - LW'(1);
        end
      end
      if (ctrl.ins) begin
        if (prev >= NIL) begin
          list_head <= idx;
        end
        if (free_total < NIL) begin
          free_total <= free_total + LW'(1);
        end
      end
      if (ctrl.build_end) begin
        list_head  <= (usable != '0) ? '0 : NIL;
        free_total <= usable;
      end
    end
  end

  // request capture, list walk and result registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      page_r   <= request.page_address[ADDR_W-1:PAGE_SHIFT];
      cnt      <= '0;
      status_r <= ST_OK;
      res_addr <= '0;
      if (request.mode == MODE_ALLOC) begin
        if (cond.head_nil) begin
          status_r <= ST_EMPTY;
        end else begin
          res_addr <= alloc_byte;
        end
      end
    end
    if (ctrl.check) begin
      if (cond.out_region) begin
        status_r <= ST_REGION;
      end
      idx   <= diff[LW-1:0];
      cur   <= list_head;
      prev  <= NIL;
      steps <= '0;
    end
    if (ctrl.step_rd) begin
      prev <= cur;
    end
    if (ctrl.step_ld) begin
      cur   <= ram_rdata;
      steps <= steps + LW'(1);
    end
    if (ctrl.build_wr) begin
      cnt <= cnt_inc;
    end
  end

  // outputs
  assign busy                 = ctrl.busy;
  assign done                 = ctrl.done;
  assign result.alloc_address = res_addr;
  assign result.status        = status_r;
  assign result.free_pages    = CNT_W'(free_total);

endmodule
